// ----- src/mdet_pkg.sv -----
package mdet_pkg;

    localparam int MAX_ORDER_DEF = 4;
    localparam int ELEM_W        = 16;
    localparam int ORDER_W       = 3;
    localparam int ACC_W         = 128;
    localparam int DET_W         = 64;
    localparam int CHUNK_W       = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CHECK,
        ST_FETCH,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic valid;
        logic odd;
        logic wrap;
    } t_perm_status;

endpackage

// ----- src/mdet_store.sv -----
module mdet_store #(
    parameter int DEPTH = mdet_pkg::MAX_ORDER_DEF * mdet_pkg::MAX_ORDER_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [AW-1:0]                      i_waddr,
    input  logic signed [mdet_pkg::ELEM_W-1:0] i_wdata,
    input  logic [AW-1:0]                      i_raddr,
    output logic signed [mdet_pkg::ELEM_W-1:0] o_rdata
);

    logic signed [mdet_pkg::ELEM_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- src/mdet_perm.sv -----
module mdet_perm #(
    parameter int MAX_ORDER = mdet_pkg::MAX_ORDER_DEF,
    parameter int CW        = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
    parameter int RW        = $clog2(MAX_ORDER + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic                        i_step,
    input  logic [RW-1:0]               i_order,
    input  logic [RW-1:0]               i_row,
    output logic [CW-1:0]               o_col,
    output mdet_pkg::t_perm_status      o_status
);

    logic [CW-1:0] r_col [MAX_ORDER];
    logic [CW-1:0] n_col [MAX_ORDER];
    logic          r_wrap;
    logic          n_wrap;
    logic          carry;
    logic          distinct;
    logic          parity;

    // odometer over column tuples, last row fastest
    always_comb begin
        carry = 1'b1;
        for (int i = MAX_ORDER - 1; i >= 0; i--) begin
            n_col[i] = r_col[i];
            if (i < int'(i_order) && carry) begin
                if (r_col[i] == CW'(i_order - RW'(1))) begin
                    n_col[i] = '0;
                end else begin
                    n_col[i] = r_col[i] + CW'(1);
                    carry    = 1'b0;
                end
            end
        end
        n_wrap = carry;
    end

    always_comb begin
        distinct = 1'b1;
        parity   = 1'b0;
        for (int i = 0; i < MAX_ORDER; i++) begin
            for (int j = i + 1; j < MAX_ORDER; j++) begin
                if (j < int'(i_order)) begin
                    if (r_col[i] == r_col[j]) begin
                        distinct = 1'b0;
                    end
                    if (r_col[i] > r_col[j]) begin
                        parity = ~parity;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
                r_col[i] <= '0;
            end
            r_wrap <= 1'b0;
        end else if (i_step) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
                r_col[i] <= n_col[i];
            end
            if (n_wrap) begin
                r_wrap <= 1'b1;
            end
        end
    end

    assign o_col           = r_col[i_row[CW-1:0]];
    assign o_status.valid  = distinct;
    assign o_status.odd    = parity;
    assign o_status.wrap   = r_wrap;

endmodule

// ----- src/matrix_determinant_core.sv -----
// sequence: n*n load words at one per cycle while o_busy is low, then a check state for each of
// the n^n column tuples plus one to see the wrap, per permutation a fetch state and a multiply
// state per product chunk for each row (cut short at a zero word) and an accumulate state, then
// a done state before the result; the multiplies use the shared 32x16 multiplier
// throughput: one matrix at a time, o_busy is high from the last word to the result
// reset: synchronous active low, order to 4, load count to zero; receiver cannot stall
module matrix_determinant_core #(
    parameter int MAX_ORDER = mdet_pkg::MAX_ORDER_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic signed [mdet_pkg::ELEM_W-1:0] i_element,
    input  logic                               i_matrix_order_we,
    input  logic [mdet_pkg::ORDER_W-1:0]       i_matrix_order,
    output logic                               o_valid,
    output logic signed [mdet_pkg::DET_W-1:0]  o_determinant,
    output logic                               o_overflow
);

    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int CW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int RW    = $clog2(MAX_ORDER + 1);
    localparam int CH    = (mdet_pkg::ELEM_W * MAX_ORDER + mdet_pkg::CHUNK_W - 1)
                           / mdet_pkg::CHUNK_W;
    localparam int PW    = CH * mdet_pkg::CHUNK_W;
    localparam int KW    = (CH > 1) ? $clog2(CH) : 1;
    localparam int EW    = mdet_pkg::ELEM_W;
    localparam int XW    = mdet_pkg::CHUNK_W + EW;

    mdet_pkg::t_state       r_state, n_state;
    logic [mdet_pkg::ORDER_W-1:0] r_order;
    logic [RW-1:0]          order;
    logic [LW-1:0]          r_load, total;
    logic [RW-1:0]          r_row;
    logic [AW-1:0]          r_base;
    logic [KW-1:0]          r_k;
    logic [PW-1:0]          r_p;
    logic [EW-1:0]          r_carry;
    logic                   r_sign;
    logic [mdet_pkg::ACC_W-1:0] r_acc;
    logic                   r_valid;
    logic signed [EW-1:0]   rdata;
    logic [EW-1:0]          mag;
    logic [XW-1:0]          prod;
    logic [CW-1:0]          col;
    mdet_pkg::t_perm_status pst;
    logic                   accept;
    logic                   clear;
    logic                   step;
    logic [mdet_pkg::ACC_W-1:0] term;
    logic [mdet_pkg::DET_W-1:0] ext;

    always_comb begin
        if (r_order == '0) begin
            order = RW'(1);
        end else if (int'(r_order) > MAX_ORDER) begin
            order = RW'(MAX_ORDER);
        end else begin
            order = RW'(r_order);
        end
        total = LW'(order) * LW'(order);
    end

    assign accept = i_start && (r_state == mdet_pkg::ST_LOAD);
    assign o_busy = (r_state != mdet_pkg::ST_LOAD);

    mdet_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_load[AW-1:0]),
        .i_wdata (i_element),
        .i_raddr (r_base + AW'(col)),
        .o_rdata (rdata)
    );

    mdet_perm #(.MAX_ORDER(MAX_ORDER), .CW(CW), .RW(RW)) u_perm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (clear),
        .i_step   (step),
        .i_order  (order),
        .i_row    (r_row),
        .o_col    (col),
        .o_status (pst)
    );

    assign mag  = rdata[EW-1] ? EW'(-rdata) : EW'(rdata);
    assign prod = XW'(r_p[r_k*mdet_pkg::CHUNK_W +: mdet_pkg::CHUNK_W]) * XW'(mag)
                  + XW'(r_carry);
    assign term = r_sign ? -mdet_pkg::ACC_W'(r_p) : mdet_pkg::ACC_W'(r_p);

    always_comb begin
        n_state = r_state;
        clear   = 1'b0;
        step    = 1'b0;
        case (r_state)
            mdet_pkg::ST_LOAD: begin
                if (accept && (r_load + LW'(1) >= total)) begin
                    clear   = 1'b1;
                    n_state = mdet_pkg::ST_CHECK;
                end
            end
            mdet_pkg::ST_CHECK: begin
                if (pst.wrap) begin
                    n_state = mdet_pkg::ST_DONE;
                end else if (pst.valid) begin
                    n_state = mdet_pkg::ST_FETCH;
                end else begin
                    step = 1'b1;
                end
            end
            mdet_pkg::ST_FETCH: begin
                n_state = mdet_pkg::ST_MUL;
            end
            mdet_pkg::ST_MUL: begin
                if (rdata == '0) begin
                    step    = 1'b1;
                    n_state = mdet_pkg::ST_CHECK;
                end else if (r_k == KW'(CH - 1)) begin
                    n_state = (r_row == order - RW'(1)) ? mdet_pkg::ST_ACC
                                                        : mdet_pkg::ST_FETCH;
                end
            end
            mdet_pkg::ST_ACC: begin
                step    = 1'b1;
                n_state = mdet_pkg::ST_CHECK;
            end
            mdet_pkg::ST_DONE: begin
                n_state = mdet_pkg::ST_LOAD;
            end
            default: begin
                n_state = mdet_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mdet_pkg::ST_LOAD;
            r_order <= mdet_pkg::ORDER_W'(4);
            r_load  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == mdet_pkg::ST_DONE);
            if (i_matrix_order_we) begin
                r_order <= i_matrix_order;
                r_load  <= '0;
            end else if (accept) begin
                r_load <= (r_load + LW'(1) >= total) ? '0 : r_load + LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            mdet_pkg::ST_LOAD: begin
                r_acc <= '0;
            end
            mdet_pkg::ST_CHECK: begin
                r_p     <= PW'(1);
                r_sign  <= pst.odd;
                r_row   <= '0;
                r_base  <= '0;
                r_k     <= '0;
                r_carry <= '0;
            end
            mdet_pkg::ST_MUL: begin
                r_p[r_k*mdet_pkg::CHUNK_W +: mdet_pkg::CHUNK_W] <=
                    prod[mdet_pkg::CHUNK_W-1:0];
                if (r_k == KW'(CH - 1)) begin
                    r_k     <= '0;
                    r_carry <= '0;
                    r_row   <= r_row + RW'(1);
                    r_base  <= r_base + AW'(order);
                    r_sign  <= r_sign ^ rdata[EW-1];
                end else begin
                    r_k     <= r_k + KW'(1);
                    r_carry <= prod[XW-1:mdet_pkg::CHUNK_W];
                end
            end
            mdet_pkg::ST_ACC: begin
                r_acc <= r_acc + term;
            end
            default: begin
            end
        endcase
    end

    assign ext = {mdet_pkg::DET_W{r_acc[mdet_pkg::DET_W-1]}};

    always_comb begin
        o_valid = r_valid;
        if (r_acc[mdet_pkg::ACC_W-1:mdet_pkg::DET_W] == ext) begin
            o_determinant = r_acc[mdet_pkg::DET_W-1:0];
            o_overflow    = 1'b0;
        end else begin
            o_determinant = r_acc[mdet_pkg::ACC_W-1]
                ? {1'b1, {(mdet_pkg::DET_W-1){1'b0}}}
                : {1'b0, {(mdet_pkg::DET_W-1){1'b1}}};
            o_overflow    = 1'b1;
        end
    end

endmodule

// ----- verif/det_checker.sv -----
module det_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_busy,
    input  logic signed [mdet_pkg::ELEM_W-1:0] i_element,
    input  logic                               i_matrix_order_we,
    input  logic [mdet_pkg::ORDER_W-1:0]       i_matrix_order,
    input  logic                               i_valid,
    input  logic signed [mdet_pkg::DET_W-1:0]  i_determinant,
    input  logic                               i_overflow,
    output int                                 o_errors,
    output int                                 o_pending
);

    localparam int MAXN  = mdet_pkg::MAX_ORDER_DEF;
    localparam int EW    = mdet_pkg::ELEM_W;
    localparam int OW    = mdet_pkg::ORDER_W;
    localparam int ACCW  = mdet_pkg::ACC_W;
    localparam int DETW  = mdet_pkg::DET_W;

    typedef struct {
        logic signed [DETW-1:0] det;
        logic                   ovf;
    } t_det_word;

    logic signed [EW-1:0] elems [MAXN*MAXN];
    logic [OW-1:0]        order_reg;
    int                   loaded;
    t_det_word            det_q [$];

    function automatic int eff_order(logic [OW-1:0] v);
        if (v == 0) return 1;
        if (v > MAXN) return MAXN;
        return int'(v);
    endfunction

    // exact determinant by summing signed products over all permutations
    function automatic logic signed [ACCW-1:0] exact_det(int n);
        logic signed [ACCW-1:0] sum;
        logic signed [ACCW-1:0] prod;
        int                     col [MAXN];
        int                     tuples;
        int                     t;
        int                     r;
        int                     k;
        int                     inv;
        bit                     dup;
        sum = '0;
        tuples = 1;
        for (r = 0; r < n; r++) tuples *= n;
        for (t = 0; t < tuples; t++) begin
            k = t;
            for (r = 0; r < n; r++) begin
                col[r] = k % n;
                k = k / n;
            end
            dup = 0;
            inv = 0;
            for (r = 0; r < n; r++)
                for (k = r + 1; k < n; k++) begin
                    if (col[r] == col[k]) dup = 1;
                    if (col[r] > col[k]) inv++;
                end
            if (!dup) begin
                prod = 1;
                for (r = 0; r < n; r++) prod = prod * elems[r*n + col[r]];
                sum = (inv % 2) ? sum - prod : sum + prod;
            end
        end
        return sum;
    endfunction

    function automatic t_det_word saturate(logic signed [ACCW-1:0] d);
        t_det_word w;
        if (&d[ACCW-1:DETW-1] || !(|d[ACCW-1:DETW-1])) begin
            w.det = d[DETW-1:0];
            w.ovf = 1'b0;
        end else begin
            w.det = d[ACCW-1] ? {1'b1, {(DETW-1){1'b0}}} : {1'b0, {(DETW-1){1'b1}}};
            w.ovf = 1'b1;
        end
        return w;
    endfunction

    assign o_pending = det_q.size();

    always @(posedge i_clk) begin
        t_det_word got;
        t_det_word exp_w;
        int        n;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            order_reg <= OW'(4);
            loaded    = 0;
            o_errors  <= 0;
            det_q.delete();
        end else begin
            if (i_matrix_order_we) begin
                order_reg <= i_matrix_order;
                loaded    = 0;
            end
            if (i_start && !i_busy) begin
                n = eff_order(order_reg);
                elems[loaded] = i_element;
                loaded++;
                if (loaded == n*n) begin
                    loaded = 0;
                    det_q.push_back(saturate(exact_det(n)));
                end
            end
            if (i_valid) begin
                got.det = i_determinant;
                got.ovf = i_overflow;
                if (det_q.size() == 0) begin
                    $error("unexpected determinant word %0d", got.det);
                    errs++;
                end else begin
                    exp_w = det_q.pop_front();
                    if (got.det !== exp_w.det) begin
                        $error("determinant: expected %0d, got %0d", exp_w.det, got.det);
                        errs++;
                    end
                    if (got.ovf !== exp_w.ovf) begin
                        $error("overflow: expected %0b, got %0b", exp_w.ovf, got.ovf);
                        errs++;
                    end
                end
            end
            o_errors <= o_errors + errs;
        end
    end
endmodule

// ----- verif/tb_top.sv -----
module tb_top;

    localparam int WATCHDOG = 20000;
    localparam int EW       = mdet_pkg::ELEM_W;
    localparam int OW       = mdet_pkg::ORDER_W;
    localparam int MAXN     = mdet_pkg::MAX_ORDER_DEF;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_start;
    logic                           o_busy;
    logic signed [EW-1:0]           i_element;
    logic                           i_matrix_order_we;
    logic [OW-1:0]                  i_matrix_order;
    logic                           o_valid;
    logic signed [mdet_pkg::DET_W-1:0] o_determinant;
    logic                           o_overflow;
    int                             errors;
    int                             pending;
    int                             idle_cycles;
    int                             burst_left;
    int                             words_sent;
    int                             cur_order;

    matrix_determinant_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_element         (i_element),
        .i_matrix_order_we (i_matrix_order_we),
        .i_matrix_order    (i_matrix_order),
        .o_valid           (o_valid),
        .o_determinant     (o_determinant),
        .o_overflow        (o_overflow)
    );

    det_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .i_busy            (o_busy),
        .i_element         (i_element),
        .i_matrix_order_we (i_matrix_order_we),
        .i_matrix_order    (i_matrix_order),
        .i_valid           (o_valid),
        .i_determinant     (o_determinant),
        .i_overflow        (o_overflow),
        .o_errors          (errors),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // no-progress watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input logic signed [EW-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_start = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_start   = 1'b1;
        i_element = value;
        do @(posedge i_clk); while (o_busy);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_order(input logic [OW-1:0] value);
        i_start = 1'b0;
        while (pending != 0 || o_busy) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_matrix_order_we = 1'b1;
        i_matrix_order    = value;
        @(negedge i_clk);
        i_matrix_order_we = 1'b0;
        if (value == 0) cur_order = 1;
        else if (value > MAXN) cur_order = MAXN;
        else cur_order = int'(value);
    endtask

    function automatic logic signed [EW-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return 16'sh8000;
            3:       return 16'sh7FFF;
            4:       return 16'(signed'($urandom_range(0, 8)) - 4);
            default: return EW'($urandom);
        endcase
    endfunction

    task automatic send_matrix();
        for (int k = 0; k < cur_order*cur_order; k++) send_word(rand_elem());
    endtask

    initial begin
        logic [OW-1:0] ord;
        i_rst_n           = 1'b0;
        i_start           = 1'b0;
        i_element         = '0;
        i_matrix_order_we = 1'b0;
        i_matrix_order    = '0;
        idle_cycles       = 0;
        burst_left        = 0;
        words_sent        = 0;
        cur_order         = 4;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // near-hadamard matrix at reset order: positive saturation
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                send_word((($countones(r & c) % 2) != 0) ? 16'sh8000 : 16'sh7FFF);
        // rows swapped: negative saturation
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                send_word((($countones((r ^ (r < 2 ? 1 : 0)) & c) % 2) != 0)
                          ? 16'sh8000 : 16'sh7FFF);
        // zero register value acts as order one
        write_order(3'd0);
        send_word(16'sh8000);
        send_word(16'sh7FFF);
        send_word('0);
        send_word(16'sh0001);
        send_word(16'shFFFF);
        write_order(3'd2);
        send_word(16'sh8000); send_word(16'sh7FFF);
        send_word(16'sh7FFF); send_word(16'sh8000);
        // partial word then reorder discards it
        send_word(16'sh1234);
        write_order(3'd7);
        send_matrix();

        while (words_sent < 430) begin
            ord = ($urandom_range(0, 4) == 0) ? OW'($urandom) : 3'($urandom_range(1, 4));
            write_order(ord);
            for (int m = $urandom_range(1, 4); m > 0; m--) send_matrix();
            if ($urandom_range(0, 9) == 0)
                for (int k = $urandom_range(1, 3); k > 0 && k < cur_order*cur_order; k--)
                    send_word(rand_elem());
        end
        write_order(3'd4);
        send_matrix();

        i_start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
src/mdet_pkg.sv
src/mdet_store.sv
src/mdet_perm.sv
src/matrix_determinant_core.sv
verif/det_checker.sv
verif/tb_top.sv
